// File: sv/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

    // Geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int KEY_W       = 16;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    // wide enough for both the capacity register and a cell index plus one
    localparam int CNT_W       = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;   // -1 on a get miss

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // One stored entry, also the word handed from a cell to its neighbor
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic             cmp;      // compare phase: latch key matches
        logic             upd;      // update phase: shift toward the back
        logic             is_put;
        logic             any_hit;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cap;      // clamped capacity
    } cmd_t;

    // Per-cell status seen by the controller
    typedef struct packed {
        logic valid;
        logic match;
    } cell_status_t;

endpackage

`default_nettype wire

// File: sv/lkvc_cell.sv
`default_nettype none

// One recency slot. Cell 0 is most recent; a cell takes its front neighbor's
// entry when everything ahead of a hit (or the whole row on insert) moves back.
module lkvc_cell (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire  [lkvc_pkg::IDX_W-1:0]     idx,
    input  wire  lkvc_pkg::cmd_t           cmd,
    input  wire  lkvc_pkg::entry_t         prev_pass,
    output lkvc_pkg::entry_t               pass,
    input  wire                            hit_in,
    output logic                           hit_out,
    input  wire  [lkvc_pkg::VAL_W-1:0]     hit_val_in,
    output logic [lkvc_pkg::VAL_W-1:0]     hit_val_out,
    output lkvc_pkg::cell_status_t         status
);

    logic                       valid_reg, valid_next;
    logic                       match_reg, match_next;
    logic [lkvc_pkg::KEY_W-1:0] key_reg,   key_next;
    logic [lkvc_pkg::VAL_W-1:0] value_reg, value_next;
    logic                       shift;
    logic                       keep;

    // hit_out: a match here or anywhere further back
    assign hit_out     = hit_in | match_reg;
    assign hit_val_out = hit_val_in | (match_reg ? value_reg : '0);

    // on an insert, entries at or past capacity-1 are evicted while moving
    assign keep = cmd.any_hit ||
                  ((lkvc_pkg::CNT_W'(idx) + lkvc_pkg::CNT_W'(1)) < cmd.cap);

    assign pass.valid = valid_reg & keep;
    assign pass.key   = key_reg;
    assign pass.value = value_reg;

    assign shift = cmd.upd & (cmd.any_hit ? hit_out : cmd.is_put);

    assign status.valid = valid_reg;
    assign status.match = match_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        match_next = match_reg;
        if (cmd.cmp)
        begin
            match_next = valid_reg && (key_reg == cmd.key);
        end
        if (shift)
        begin
            valid_next = prev_pass.valid;
            key_next   = prev_pass.key;
            value_next = prev_pass.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// File: sv/lru_key_value_cache.sv
`default_nettype none

// LRU key/value cache, fully associative, up to 16 entries held in a row of
// cells ordered by recency (cell 0 = most recent). A word is accepted when
// start is high and busy is low. Each word goes through a compare cycle,
// where every cell checks its key against the request in parallel, and an
// update cycle, where the hit entry (or the new one) moves to the front and
// the cells ahead of it step back one place. busy is high only during the
// compare cycle, so a new word can be taken in the update cycle of the
// previous one. A get returns one result word (found, read_value) on done,
// in the cycle after its update cycle; a put returns nothing. done is a
// one-cycle strobe and the receiver cannot stall it. On a miss, read_value
// is -1. Capacity (cfg_wdata, reset 16, values above 16 act as 16) is
// written with cfg_we; the user must write it only while idle, which the
// block does not enforce. Lowering it evicts nothing until the next insert,
// which drops the oldest entries until the new key fits. Capacity 0 stores
// nothing new, but puts to present keys still update them. The store is
// empty after reset; there is no clearing pass.
module lru_key_value_cache (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire                            mode,
    input  wire  [lkvc_pkg::KEY_W-1:0]     lookup_key,
    input  wire  signed [lkvc_pkg::VAL_W-1:0] write_value,
    output logic                           done,
    output logic                           found,
    output logic signed [lkvc_pkg::VAL_W-1:0] read_value,
    input  wire                            cfg_we,
    input  wire  [lkvc_pkg::CAP_W-1:0]     cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    state_t                     state_reg, state_next;
    logic                       done_reg, done_next;
    logic                       found_reg, found_next;
    logic [lkvc_pkg::VAL_W-1:0] read_value_reg, read_value_next;
    logic [lkvc_pkg::CAP_W-1:0] cap_reg, cap_next;

    // request word, latched at accept
    logic                       op_reg;
    logic [lkvc_pkg::KEY_W-1:0] key_reg;
    logic [lkvc_pkg::VAL_W-1:0] wdata_reg;

    logic                       accept;
    logic [lkvc_pkg::CNT_W-1:0] cap_eff;
    lkvc_pkg::cmd_t             cmd;
    lkvc_pkg::entry_t           front;

    lkvc_pkg::entry_t           pass     [lkvc_pkg::MAX_ENTRIES];
    lkvc_pkg::cell_status_t     status   [lkvc_pkg::MAX_ENTRIES];
    logic                       hit_c    [lkvc_pkg::MAX_ENTRIES+1];
    logic [lkvc_pkg::VAL_W-1:0] hit_val_c[lkvc_pkg::MAX_ENTRIES+1];
    logic [lkvc_pkg::MAX_ENTRIES-1:0] valid_vec;
    logic [lkvc_pkg::MAX_ENTRIES-1:0] match_vec;

    assign busy   = (state_reg == S_CMP);
    assign accept = start && !busy;

    // clamp capacity to the number of cells
    assign cap_eff = (lkvc_pkg::CNT_W'(cap_reg) > lkvc_pkg::CNT_W'(lkvc_pkg::MAX_ENTRIES))
                   ? lkvc_pkg::CNT_W'(lkvc_pkg::MAX_ENTRIES)
                   : lkvc_pkg::CNT_W'(cap_reg);

    assign cmd.cmp     = (state_reg == S_CMP);
    assign cmd.upd     = (state_reg == S_UPD);
    assign cmd.is_put  = (op_reg == lkvc_pkg::MODE_PUT);
    assign cmd.any_hit = hit_c[0];
    assign cmd.key     = key_reg;
    assign cmd.cap     = cap_eff;

    // entry that enters cell 0: the hit entry (value updated on put) or the
    // new key; with capacity 0 an insert brings in nothing
    assign front.valid = hit_c[0] || (cap_eff != '0);
    assign front.key   = key_reg;
    assign front.value = cmd.is_put ? wdata_reg : hit_val_c[0];

    // hit and hit-value chains run from the back cell to the front
    assign hit_c[lkvc_pkg::MAX_ENTRIES]     = 1'b0;
    assign hit_val_c[lkvc_pkg::MAX_ENTRIES] = '0;

    for (genvar i = 0; i < lkvc_pkg::MAX_ENTRIES; i++)
    begin : g_cell
        lkvc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .idx         (lkvc_pkg::IDX_W'(i)),
            .cmd         (cmd),
            .prev_pass   ((i == 0) ? front : pass[(i == 0) ? 0 : i-1]),
            .pass        (pass[i]),
            .hit_in      (hit_c[i+1]),
            .hit_out     (hit_c[i]),
            .hit_val_in  (hit_val_c[i+1]),
            .hit_val_out (hit_val_c[i]),
            .status      (status[i])
        );
        assign valid_vec[i] = status[i].valid;
        assign match_vec[i] = status[i].match;
    end

    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        found_next      = found_reg;
        read_value_next = read_value_reg;
        cap_next        = cfg_we ? cfg_wdata : cap_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next = accept ? S_CMP : S_IDLE;
                if (op_reg == lkvc_pkg::MODE_GET)
                begin
                    done_next       = 1'b1;
                    found_next      = hit_c[0];
                    read_value_next = hit_c[0] ? hit_val_c[0] : lkvc_pkg::MISS_VALUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            read_value_reg <= lkvc_pkg::MISS_VALUE;
            cap_reg        <= lkvc_pkg::CAP_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            found_reg      <= found_next;
            read_value_reg <= read_value_next;
            cap_reg        <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= mode;
            key_reg   <= lookup_key;
            wdata_reg <= write_value;
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;

`ifndef SYNTHESIS
    // results only come out of an update cycle
    a_done_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_UPD))
        else $error("done without a preceding update cycle");

    // keys are unique, so at most one cell can match
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> $onehot0(match_vec))
        else $error("more than one cell matched");

    // valid entries always fill the row from the front with no holes
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + {{lkvc_pkg::MAX_ENTRIES{1'b0}}, 1'b1}))
        else $error("valid entries not contiguous from cell 0");

    // a miss always reports -1
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (read_value_reg == lkvc_pkg::MISS_VALUE))
        else $error("miss did not return -1");
`endif

endmodule

`default_nettype wire
